// ----- rtl/etok_pkg.sv -----
package etok_pkg;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } etok_in_t;

    typedef struct packed {
        logic [2:0]  token_kind;
        logic [31:0] token_start;
        logic [15:0] token_length;
        logic [7:0]  first_char;
        logic        last_in_run;
    } etok_out_t;

    // up to two tokens caused by one character, oldest in first
    typedef struct packed {
        logic [1:0] count;
        etok_out_t  first;
        etok_out_t  second;
    } etok_pair_t;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_NUMBER,
        MODE_IDENT
    } etok_mode_t;

    typedef enum logic [2:0] {
        CLS_DIGIT,
        CLS_ALPHA,
        CLS_OPERATOR,
        CLS_SPACE,
        CLS_OTHER
    } etok_class_t;

    localparam logic [2:0] KIND_NUMBER   = 3'd0;
    localparam logic [2:0] KIND_OPERATOR = 3'd1;
    localparam logic [2:0] KIND_KEYWORD  = 3'd2;
    localparam logic [2:0] KIND_IDENT    = 3'd3;
    localparam logic [2:0] KIND_UNKNOWN  = 3'd4;

    localparam logic [7:0] CHAR_DIGIT_0  = 8'h30;
    localparam logic [7:0] CHAR_DIGIT_9  = 8'h39;
    localparam logic [7:0] CHAR_LOWER_A  = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z  = 8'h7A;
    localparam logic [7:0] CHAR_UPPER_A  = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z  = 8'h5A;
    localparam logic [7:0] CHAR_PLUS     = 8'h2B;
    localparam logic [7:0] CHAR_MINUS    = 8'h2D;
    localparam logic [7:0] CHAR_STAR     = 8'h2A;
    localparam logic [7:0] CHAR_SLASH    = 8'h2F;
    localparam logic [7:0] CHAR_EQUALS   = 8'h3D;
    localparam logic [7:0] CHAR_SPACE    = 8'h20;
    localparam logic [7:0] CHAR_TAB      = 8'h09;
    localparam logic [7:0] CHAR_CR       = 8'h0D;
    localparam logic [7:0] CHAR_I        = 8'h69;
    localparam logic [7:0] CHAR_N        = 8'h6E;
    localparam logic [7:0] CHAR_T        = 8'h74;
    localparam logic [7:0] CHAR_F        = 8'h66;
    localparam logic [7:0] CHAR_L        = 8'h6C;
    localparam logic [7:0] CHAR_O        = 8'h6F;
    localparam logic [7:0] CHAR_A        = 8'h61;

    function automatic etok_class_t etok_classify(logic [7:0] c);
        etok_class_t cls;
        if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9)
        begin
            cls = CLS_DIGIT;
        end
        else if ((c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) ||
                 (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z))
        begin
            cls = CLS_ALPHA;
        end
        else if (c == CHAR_PLUS || c == CHAR_MINUS || c == CHAR_STAR ||
                 c == CHAR_SLASH || c == CHAR_EQUALS)
        begin
            cls = CLS_OPERATOR;
        end
        else if (c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR))
        begin
            cls = CLS_SPACE;
        end
        else
        begin
            cls = CLS_OTHER;
        end
        return cls;
    endfunction

endpackage

// ----- rtl/etok_core.sv -----
module etok_core
    import etok_pkg::*;
#(
    parameter int POSITION_BITS = 32,
    parameter int LENGTH_BITS   = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  etok_in_t   item,
    output etok_pair_t pair
);

    localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

    etok_mode_t               mode_reg, mode_next, mode_tok;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [POSITION_BITS-1:0] start_reg, start_next;
    logic [LENGTH_BITS-1:0]   len_reg, len_next;
    logic [7:0]               first_reg, first_next;
    logic [1:0]               cand_reg, cand_next, cand_ext;

    etok_class_t cls;
    logic        cont;
    logic        emit_old;
    logic        single_valid;
    logic        final_valid;
    etok_out_t   old_tok;
    etok_out_t   single_tok;
    etok_out_t   final_tok;
    etok_out_t   second_tok;

    function automatic etok_out_t token_desc(
        etok_mode_t               mode,
        logic [POSITION_BITS-1:0] start,
        logic [LENGTH_BITS-1:0]   len,
        logic [7:0]               first,
        logic [1:0]               cand
    );
        logic [POSITION_BITS+31:0] start_ext;
        logic [LENGTH_BITS+15:0]   len_ext;
        logic                      kw;
        etok_out_t                 t;
        start_ext = {32'd0, start};
        len_ext   = {16'd0, len};
        kw = (cand[0] && len == LENGTH_BITS'(3)) || (cand[1] && len == LENGTH_BITS'(5));
        if (mode == MODE_IDENT)
        begin
            t.token_kind = kw ? KIND_KEYWORD : KIND_IDENT;
        end
        else
        begin
            t.token_kind = KIND_NUMBER;
        end
        t.token_start  = start_ext[31:0];
        t.token_length = len_ext[15:0];
        t.first_char   = first;
        t.last_in_run  = 1'b0;
        return t;
    endfunction

    always_comb
    begin
        cls  = etok_classify(item.char_code);
        cont = (mode_reg == MODE_NUMBER && cls == CLS_DIGIT) ||
               (mode_reg == MODE_IDENT && (cls == CLS_DIGIT || cls == CLS_ALPHA));
        emit_old = (mode_reg != MODE_IDLE) && !cont;
        old_tok  = token_desc(mode_reg, start_reg, len_reg, first_reg, cand_reg);

        // drop keyword candidates that the new character rules out
        cand_ext[0] = cand_reg[0] &&
                      ((len_reg == LENGTH_BITS'(1) && item.char_code == CHAR_N) ||
                       (len_reg == LENGTH_BITS'(2) && item.char_code == CHAR_T));
        cand_ext[1] = cand_reg[1] &&
                      ((len_reg == LENGTH_BITS'(1) && item.char_code == CHAR_L) ||
                       (len_reg == LENGTH_BITS'(2) && item.char_code == CHAR_O) ||
                       (len_reg == LENGTH_BITS'(3) && item.char_code == CHAR_A) ||
                       (len_reg == LENGTH_BITS'(4) && item.char_code == CHAR_T));

        mode_tok   = mode_reg;
        start_next = start_reg;
        len_next   = len_reg;
        first_next = first_reg;
        cand_next  = cand_reg;

        if (cont)
        begin
            len_next  = (len_reg != LEN_MAX) ? len_reg + LENGTH_BITS'(1) : len_reg;
            cand_next = cand_ext;
        end
        else
        begin
            case (cls)
                CLS_DIGIT:
                begin
                    mode_tok   = MODE_NUMBER;
                    start_next = pos_reg;
                    len_next   = LENGTH_BITS'(1);
                    first_next = item.char_code;
                    cand_next  = 2'b00;
                end
                CLS_ALPHA:
                begin
                    mode_tok   = MODE_IDENT;
                    start_next = pos_reg;
                    len_next   = LENGTH_BITS'(1);
                    first_next = item.char_code;
                    cand_next  = {item.char_code == CHAR_F, item.char_code == CHAR_I};
                end
                default:
                begin
                    mode_tok = MODE_IDLE;
                end
            endcase
        end

        single_valid = !cont && (cls == CLS_OPERATOR || cls == CLS_OTHER);
        single_tok = token_desc(MODE_NUMBER, pos_reg, LENGTH_BITS'(1), item.char_code, 2'b00);
        single_tok.token_kind = (cls == CLS_OPERATOR) ? KIND_OPERATOR : KIND_UNKNOWN;

        final_valid = item.last_char && (mode_tok != MODE_IDLE);
        final_tok   = token_desc(mode_tok, start_next, len_next, first_next, cand_next);

        second_tok = single_valid ? single_tok : final_tok;
        second_tok.last_in_run = 1'b1;

        pair.count  = {emit_old && (single_valid || final_valid),
                       emit_old != (single_valid || final_valid)};
        pair.first  = emit_old ? old_tok : second_tok;
        pair.first.last_in_run = !(emit_old && (single_valid || final_valid));
        pair.second = second_tok;

        if (item.last_char)
        begin
            mode_next = MODE_IDLE;
            pos_next  = '0;
        end
        else
        begin
            mode_next = mode_tok;
            pos_next  = pos_reg + POSITION_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            pos_reg  <= '0;
        end
        else if (step)
        begin
            mode_reg <= mode_next;
            pos_reg  <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            start_reg <= start_next;
            len_reg   <= len_next;
            first_reg <= first_next;
            cand_reg  <= cand_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
        step && item.last_char |=> mode_reg == MODE_IDLE && pos_reg == '0)
        else $error("scan state not cleared after end of text");

    a_open_length_one: assert property (@(posedge clk) disable iff (!rst_n)
        step && !cont && !item.last_char && (cls == CLS_DIGIT || cls == CLS_ALPHA)
        |=> len_reg == LENGTH_BITS'(1))
        else $error("new token does not start at length one");

    a_mode_legal: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == MODE_IDLE || mode_reg == MODE_NUMBER || mode_reg == MODE_IDENT)
        else $error("scan mode out of range");
`endif

endmodule

// ----- rtl/expression_tokenizer.sv -----
// Streaming tokenizer for simple arithmetic expressions.
// Input channel (char_valid/char_ready/char_item): one character per transfer,
// with last_char set on the final character of a text.
// Output channel (token_valid/token_ready/token_item): token descriptors with
// kind, start offset, length and first character; last_in_run marks the last
// token caused by one character.
// A character causes zero, one or two tokens. Numbers and identifiers are
// reported when the next character cannot extend them or when the text ends.
// A token caused by a character passes the input stage register and then the
// token queue before it is offered.
// Throughput: one character per cycle while the output keeps up; a character
// that causes two tokens needs two output transfers.
// A four-entry token queue sits behind the scanner, so characters keep being
// taken while tokens wait; the scanner stalls once the queue has fewer than two free
// entries. A stalled receiver holds the current token and its payload stable.
// Reset clears the scanner to idle at position zero and empties the queue.
module expression_tokenizer
    import etok_pkg::*;
#(
    parameter int POSITION_BITS = 32,
    parameter int LENGTH_BITS   = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      char_valid,
    output logic      char_ready,
    input  etok_in_t  char_item,
    output logic      token_valid,
    input  logic      token_ready,
    output etok_out_t token_item
);

    logic       a_valid_reg, a_valid_next;
    etok_in_t   a_item_reg;
    etok_out_t  q_reg [4];
    logic [1:0] head_reg, head_next;
    logic [2:0] count_reg, count_next;
    logic [1:0] tail;
    logic [1:0] tail_plus;
    logic       step;
    logic       accept;
    logic       pop;
    etok_pair_t pair;

    etok_core #(
        .POSITION_BITS (POSITION_BITS),
        .LENGTH_BITS   (LENGTH_BITS)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .item  (a_item_reg),
        .pair  (pair)
    );

    always_comb
    begin
        step        = a_valid_reg && (count_reg <= 3'd2);
        char_ready  = !a_valid_reg || step;
        accept      = char_valid && char_ready;
        token_valid = (count_reg != 3'd0);
        token_item  = q_reg[head_reg];
        pop         = token_valid && token_ready;
        tail        = head_reg + count_reg[1:0];
        tail_plus   = tail + 2'd1;
        head_next   = head_reg + {1'b0, pop};
        count_next  = count_reg - {2'b00, pop} + (step ? {1'b0, pair.count} : 3'd0);
        if (accept)
        begin
            a_valid_next = 1'b1;
        end
        else if (step)
        begin
            a_valid_next = 1'b0;
        end
        else
        begin
            a_valid_next = a_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            head_reg    <= 2'd0;
            count_reg   <= 3'd0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            head_reg    <= head_next;
            count_reg   <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_item_reg <= char_item;
        end
        if (step && pair.count != 2'd0)
        begin
            q_reg[tail] <= pair.first;
        end
        if (step && pair.count == 2'd2)
        begin
            q_reg[tail_plus] <= pair.second;
        end
    end

`ifndef NO_ASSERTIONS
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 3'd4)
        else $error("token queue overflow");

    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        step && pair.count == 2'd2 |-> !pair.first.last_in_run && pair.second.last_in_run)
        else $error("last_in_run misplaced in token pair");

    a_single_marked: assert property (@(posedge clk) disable iff (!rst_n)
        step && pair.count == 2'd1 |-> pair.first.last_in_run)
        else $error("single token not marked last in run");

    a_stage_drains: assert property (@(posedge clk) disable iff (!rst_n)
        step && !accept |=> !a_valid_reg)
        else $error("input stage kept a consumed character");
`endif

endmodule

// ----- tb/expression_tokenizer_checker.sv -----
`timescale 1ns / 100ps

module expression_tokenizer_checker
    import etok_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      char_valid,
    input  logic      char_ready,
    input  etok_in_t  char_item,
    input  logic      token_valid,
    input  logic      token_ready,
    input  etok_out_t token_item,
    output int        fail_count,
    output int        pending_tokens
);

    etok_mode_t  scan_mode;
    logic [31:0] next_pos;
    logic [31:0] open_start;
    logic [15:0] open_len;
    logic [7:0]  open_first;
    logic        int_live;
    logic        float_live;
    etok_out_t   expected_tokens[$];

    function automatic etok_class_t char_class(input logic [7:0] c);
        logic [7:0] folded;
        folded = c | 8'h20;
        if (c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR))
        begin
            return CLS_SPACE;
        end
        if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9)
        begin
            return CLS_DIGIT;
        end
        if (folded >= CHAR_LOWER_A && folded <= CHAR_LOWER_Z)
        begin
            return CLS_ALPHA;
        end
        case (c)
            CHAR_PLUS, CHAR_MINUS, CHAR_STAR, CHAR_SLASH, CHAR_EQUALS:
            begin
                return CLS_OPERATOR;
            end
            default:
            begin
                return CLS_OTHER;
            end
        endcase
    endfunction

    function automatic etok_out_t closed_token();
        etok_out_t t;
        t.token_kind = KIND_NUMBER;
        if (scan_mode == MODE_IDENT)
        begin
            t.token_kind = ((int_live && open_len == 16'd3) ||
                            (float_live && open_len == 16'd5)) ? KIND_KEYWORD : KIND_IDENT;
        end
        t.token_start  = open_start;
        t.token_length = open_len;
        t.first_char   = open_first;
        t.last_in_run  = 1'b0;
        return t;
    endfunction

    function automatic etok_out_t single_token(input logic [2:0] kind, input logic [7:0] c);
        etok_out_t t;
        t.token_kind   = kind;
        t.token_start  = next_pos;
        t.token_length = 16'd1;
        t.first_char   = c;
        t.last_in_run  = 1'b0;
        return t;
    endfunction

    task automatic clear_scanner();
        scan_mode  = MODE_IDLE;
        next_pos   = '0;
        open_start = '0;
        open_len   = '0;
        open_first = '0;
        int_live   = 1'b0;
        float_live = 1'b0;
    endtask

    task automatic scan_char(input etok_in_t item);
        etok_out_t   found[2];
        etok_class_t cls;
        logic [7:0]  c;
        logic        taken;
        int          n;
        int          i;
        c = item.char_code;
        cls = char_class(c);
        n = 0;
        taken = 1'b0;
        if (scan_mode != MODE_IDLE)
        begin
            if (cls == CLS_DIGIT || (cls == CLS_ALPHA && scan_mode == MODE_IDENT))
            begin
                if (!((open_len == 16'd1 && c == CHAR_N) || (open_len == 16'd2 && c == CHAR_T)))
                begin
                    int_live = 1'b0;
                end
                if (!((open_len == 16'd1 && c == CHAR_L) || (open_len == 16'd2 && c == CHAR_O) ||
                      (open_len == 16'd3 && c == CHAR_A) || (open_len == 16'd4 && c == CHAR_T)))
                begin
                    float_live = 1'b0;
                end
                if (open_len != 16'hFFFF)
                begin
                    open_len = open_len + 16'd1;
                end
                taken = 1'b1;
            end
            else
            begin
                found[n] = closed_token();
                n++;
                scan_mode = MODE_IDLE;
            end
        end
        if (!taken)
        begin
            case (cls)
                CLS_DIGIT, CLS_ALPHA:
                begin
                    scan_mode  = (cls == CLS_DIGIT) ? MODE_NUMBER : MODE_IDENT;
                    open_start = next_pos;
                    open_len   = 16'd1;
                    open_first = c;
                    int_live   = (cls == CLS_ALPHA) && (c == CHAR_I);
                    float_live = (cls == CLS_ALPHA) && (c == CHAR_F);
                end
                CLS_OPERATOR:
                begin
                    found[n] = single_token(KIND_OPERATOR, c);
                    n++;
                end
                CLS_OTHER:
                begin
                    found[n] = single_token(KIND_UNKNOWN, c);
                    n++;
                end
                default:
                begin
                end
            endcase
        end
        if (item.last_char)
        begin
            if (scan_mode != MODE_IDLE)
            begin
                found[n] = closed_token();
                n++;
            end
            clear_scanner();
        end
        else
        begin
            next_pos = next_pos + 32'd1;
        end
        for (i = 0; i < n; i++)
        begin
            found[i].last_in_run = (i == n - 1);
            expected_tokens.insert(expected_tokens.size(), found[i]);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    task automatic compare_token(input etok_out_t got);
        etok_out_t want;
        if (expected_tokens.size() == 0)
        begin
            $display("%0t: token expected none got %h", $time, got);
            fail_count++;
        end
        else
        begin
            want = expected_tokens.pop_front();
            check_field("token_kind", 32'(want.token_kind), 32'(got.token_kind));
            check_field("token_start", want.token_start, got.token_start);
            check_field("token_length", 32'(want.token_length), 32'(got.token_length));
            check_field("first_char", 32'(want.first_char), 32'(got.first_char));
            check_field("last_in_run", 32'(want.last_in_run), 32'(got.last_in_run));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_scanner();
            expected_tokens.delete();
            fail_count = 0;
        end
        else
        begin
            if (char_valid && char_ready)
            begin
                scan_char(char_item);
            end
            if (token_valid && token_ready)
            begin
                compare_token(token_item);
            end
        end
        pending_tokens = expected_tokens.size();
    end

endmodule

// ----- tb/expression_tokenizer_tb.sv -----
`timescale 1ns / 100ps

module expression_tokenizer_tb;
    import etok_pkg::*;

    localparam int CYCLE_LIMIT     = 1000000;
    localparam int ITEMS_PER_PHASE = 285;
    localparam int DRAIN_CYCLES    = 10;

    logic       clk         = 1'b0;
    logic       rst_n       = 1'b0;
    logic       char_valid  = 1'b0;
    logic       char_ready;
    etok_in_t   char_item   = '0;
    logic       token_valid;
    logic       token_ready = 1'b0;
    etok_out_t  token_item;
    int         fail_count;
    int         pending_tokens;
    int         send_idle_pct = 33;
    int         recv_idle_pct = 73;
    int         chars_sent    = 0;
    int         cycles        = 0;
    logic [7:0] text_buf[$];

    expression_tokenizer u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .char_valid  (char_valid),
        .char_ready  (char_ready),
        .char_item   (char_item),
        .token_valid (token_valid),
        .token_ready (token_ready),
        .token_item  (token_item)
    );

    expression_tokenizer_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .char_valid     (char_valid),
        .char_ready     (char_ready),
        .char_item      (char_item),
        .token_valid    (token_valid),
        .token_ready    (token_ready),
        .token_item     (token_item),
        .fail_count     (fail_count),
        .pending_tokens (pending_tokens)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        token_ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic logic [7:0] rand_alnum(input logic letters_only);
        logic [7:0] r;
        r = letters_only ? 8'($urandom_range(10, 61)) : 8'($urandom_range(61));
        if (r < 8'd10)
        begin
            return CHAR_DIGIT_0 + r;
        end
        if (r < 8'd36)
        begin
            return CHAR_UPPER_A + (r - 8'd10);
        end
        return CHAR_LOWER_A + (r - 8'd36);
    endfunction

    // start and end at a falling edge; valid stays high between back-to-back transfers
    task automatic send_char(input logic [7:0] code, input logic last);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
        begin
            gap++;
        end
        if (gap > 0)
        begin
            char_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        char_valid <= 1'b1;
        char_item  <= '{char_code: code, last_char: last};
        do
        begin
            @(posedge clk);
        end
        while (!char_ready);
        chars_sent++;
        @(negedge clk);
    endtask

    task automatic send_text();
        int i;
        for (i = 0; i < text_buf.size(); i++)
        begin
            send_char(text_buf[i], i == text_buf.size() - 1);
        end
    endtask

    task automatic send_string(input string s);
        int i;
        text_buf.delete();
        for (i = 0; i < s.len(); i++)
        begin
            text_buf.insert(text_buf.size(), s[i]);
        end
        send_text();
    endtask

    task automatic build_text();
        int         tokens;
        int         len;
        int         t;
        int         i;
        string      w;
        logic [7:0] c;
        text_buf.delete();
        tokens = $urandom_range(1, 8);
        for (t = 0; t < tokens; t++)
        begin
            case ($urandom_range(9))
                0, 1:
                begin
                    len = $urandom_range(1, 5);
                    for (i = 0; i < len; i++)
                    begin
                        text_buf.insert(text_buf.size(), CHAR_DIGIT_0 + 8'($urandom_range(9)));
                    end
                end
                2, 3:
                begin
                    text_buf.insert(text_buf.size(), rand_alnum(1'b1));
                    len = $urandom_range(0, 5);
                    for (i = 0; i < len; i++)
                    begin
                        text_buf.insert(text_buf.size(), rand_alnum(1'b0));
                    end
                end
                4:
                begin
                    case ($urandom_range(7))
                        0: w = "int";
                        1: w = "float";
                        2: w = "in";
                        3: w = "floa";
                        4: w = "intx";
                        5: w = "float9";
                        6: w = "i";
                        default: w = "f";
                    endcase
                    for (i = 0; i < w.len(); i++)
                    begin
                        text_buf.insert(text_buf.size(), w[i]);
                    end
                end
                5, 6:
                begin
                    case ($urandom_range(4))
                        0: c = CHAR_PLUS;
                        1: c = CHAR_MINUS;
                        2: c = CHAR_STAR;
                        3: c = CHAR_SLASH;
                        default: c = CHAR_EQUALS;
                    endcase
                    text_buf.insert(text_buf.size(), c);
                end
                7:
                begin
                    c = 8'($urandom_range(5));
                    text_buf.insert(text_buf.size(),
                                    (c == 8'd0) ? CHAR_SPACE : CHAR_TAB + c - 8'd1);
                end
                8:
                begin
                    text_buf.insert(text_buf.size(), 8'($urandom_range(255)));
                end
                default:
                begin
                    text_buf.insert(text_buf.size(), 8'($urandom_range(128, 255)));
                end
            endcase
            if ($urandom_range(1) == 1)
            begin
                text_buf.insert(text_buf.size(), CHAR_SPACE);
            end
        end
    endtask

    task automatic run_phase(input int send_pct, input int recv_pct);
        int target;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        target = chars_sent + ITEMS_PER_PHASE;
        while (chars_sent < target)
        begin
            build_text();
            send_text();
        end
    endtask

    initial
    begin
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_string("int\tfloat");
        send_string("9z+-*/=");
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b0);
        send_char(8'h80, 1'b0);
        send_char(8'h7F, 1'b0);
        send_char(CHAR_CR, 1'b1);
        send_string("F0 ");

        run_phase(33, 73);
        run_phase(73, 33);
        run_phase(0, 0);

        char_valid <= 1'b0;
        while (pending_tokens != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
